>>> sv/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants for the minimum window substring finder.
// ----------------------------------------------------------------------------
package mws_pkg;

	localparam int DEF_MAX_TEXT      = 1024;
	localparam int DEF_MAX_PATTERN   = 256;
	localparam int DEF_ALPHABET_SIZE = 128;

	localparam int OP_W     = 2;
	localparam int SYM_W    = 7;
	localparam int SYM_N    = 1 << SYM_W;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;
	localparam int LEN_W    = 11;

	localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [SYM_W-1:0] symbol;
	} in_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  window_start;
		logic [LEN_W-1:0]    window_length;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic ovf_set;   // dropped beat, flag overflow
		logic pat_rd;    // read count of incoming symbol, latch code
		logic pat_upd;   // count +1, pattern length +1, still needed +1
		logic txt_wr;    // store symbol, right +1, read its count, latch code
		logic txt_upd;   // count -1, still needed -1 if it was positive
		logic shr_best;  // update best window, read text at left
		logic shr_rd;    // read count of left symbol, latch code
		logic shr_upd;   // count +1, still needed +1 if now positive, left +1
		logic fin;       // load result, clear window, counts and flags
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic right_zero;
		logic text_full;
		logic pat_full;
		logic plen_zero;
		logic shrink_go;
		logic out_busy;
	} stat_t;

endpackage

>>> sv/mws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_dp
// Datapath: count memory with valid bits, text memory, window indexes,
// best window and the result register.
// ----------------------------------------------------------------------------
module mws_dp #(
	parameter int MAX_TEXT      = mws_pkg::DEF_MAX_TEXT,
	parameter int MAX_PATTERN   = mws_pkg::DEF_MAX_PATTERN,
	parameter int ALPHABET_SIZE = mws_pkg::DEF_ALPHABET_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mws_pkg::in_beat_t  in_data,
	input  mws_pkg::cmd_t      cmd,
	output mws_pkg::stat_t     stat,
	input  logic               out_ready,
	output logic               out_valid,
	output mws_pkg::out_beat_t out_data
);
	import mws_pkg::*;

	localparam int CW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int TA = $clog2(MAX_TEXT);
	localparam int IW = $clog2(MAX_TEXT + 1);
	localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN + 1) : 1;
	localparam int NW = $clog2(MAX_TEXT + MAX_PATTERN + 1) + 1;

	logic [CW-1:0] code_lut [SYM_N];

	for (genvar g = 0; g < SYM_N; g++) begin : g_lut
		assign code_lut[g] = CW'(g % ALPHABET_SIZE);
	end

	logic signed [NW-1:0] cnt_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] cnt_vld_q;
	logic signed [NW-1:0] cnt_rd_q;
	logic [CW-1:0] text_mem [MAX_TEXT];
	logic [CW-1:0] text_rd_q;

	logic [CW-1:0] code_q;
	logic [IW-1:0] left_q, right_q;
	logic [PW-1:0] still_q, plen_q;
	logic [TA-1:0] best_start_q;
	logic [IW-1:0] best_len_q;
	logic best_valid_q, ovf_q;
	logic out_valid_q;
	out_beat_t out_q;

	logic [CW-1:0] code_in, cnt_raddr;
	logic cnt_rd_en, cnt_wr_en;
	logic signed [NW-1:0] cnt_inc, cnt_dec, cnt_wdata;
	logic [IW-1:0] win_len;
	logic [TA+START_W-1:0] start_ext;
	logic [IW+LEN_W-1:0] len_ext;

	assign code_in   = code_lut[in_data.symbol];
	assign cnt_rd_en = cmd.pat_rd | cmd.txt_wr | cmd.shr_rd;
	assign cnt_raddr = cmd.shr_rd ? text_rd_q : code_in;
	assign cnt_wr_en = cmd.pat_upd | cmd.txt_upd | cmd.shr_upd;
	assign cnt_inc   = cnt_rd_q + NW'(1);
	assign cnt_dec   = cnt_rd_q - NW'(1);
	assign cnt_wdata = cmd.txt_upd ? cnt_dec : cnt_inc;
	assign win_len   = right_q - left_q;
	assign start_ext = {{START_W{1'b0}}, best_start_q};
	assign len_ext   = {{LEN_W{1'b0}}, best_len_q};

	always_ff @(posedge clk) begin
		if (cnt_wr_en) begin
			cnt_mem[code_q] <= cnt_wdata;
		end
		if (cnt_rd_en) begin
			cnt_rd_q <= cnt_vld_q[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.txt_wr) begin
			text_mem[right_q[TA-1:0]] <= code_in;
		end
		if (cmd.shr_best) begin
			text_rd_q <= text_mem[left_q[TA-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			code_q       <= '0;
			left_q       <= '0;
			right_q      <= '0;
			still_q      <= '0;
			plen_q       <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			best_valid_q <= 1'b0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.pat_rd | cmd.txt_wr) begin
				code_q <= code_in;
			end
			if (cmd.shr_rd) begin
				code_q <= text_rd_q;
			end
			if (cnt_wr_en) begin
				cnt_vld_q[code_q] <= 1'b1;
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.pat_upd) begin
				plen_q  <= plen_q + PW'(1);
				still_q <= still_q + PW'(1);
			end
			if (cmd.txt_wr) begin
				right_q <= right_q + IW'(1);
			end
			if (cmd.txt_upd && cnt_rd_q > 0) begin
				still_q <= still_q - PW'(1);
			end
			if (cmd.shr_best && (!best_valid_q || win_len < best_len_q)) begin
				best_valid_q <= 1'b1;
				best_len_q   <= win_len;
				best_start_q <= left_q[TA-1:0];
			end
			if (cmd.shr_upd) begin
				left_q <= left_q + IW'(1);
				if (cnt_inc > 0) begin
					still_q <= still_q + PW'(1);
				end
			end
			if (cmd.fin) begin
				cnt_vld_q    <= '0;
				left_q       <= '0;
				right_q      <= '0;
				still_q      <= '0;
				plen_q       <= '0;
				best_start_q <= '0;
				best_len_q   <= '0;
				best_valid_q <= 1'b0;
				ovf_q        <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (ovf_q) begin
				out_q <= '{ST_OVERFLOW, '0, '0};
			end else if (plen_q == '0 || !best_valid_q) begin
				out_q <= '{ST_NONE, '0, '0};
			end else begin
				out_q <= '{ST_FOUND, start_ext[START_W-1:0], len_ext[LEN_W-1:0]};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.right_zero = (right_q == '0);
	assign stat.text_full  = (right_q == IW'(MAX_TEXT));
	assign stat.pat_full   = (plen_q == PW'(MAX_PATTERN));
	assign stat.plen_zero  = (plen_q == '0);
	assign stat.shrink_go  = (still_q == '0) && (left_q < right_q);
	assign stat.out_busy   = out_valid_q & ~out_ready;

`ifndef SYNTHESIS
	a_left_le_right: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= right_q) else $error("window left beyond right");
	a_still_le_plen: assert property (@(posedge clk) disable iff (!arst_n)
		still_q <= plen_q) else $error("still needed exceeds pattern length");
	a_best_len: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> (best_len_q != '0 && best_len_q <= right_q))
		else $error("best window length out of range");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (right_q == '0 && plen_q == '0 && !ovf_q && out_valid_q))
		else $error("finish did not clear state");
`endif

endmodule

>>> sv/mws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_ctrl
// Controller: sequences pattern loads, text updates, finish beats and the left shrink loop.
// ----------------------------------------------------------------------------
module mws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mws_pkg::in_beat_t in_data,
	input  mws_pkg::stat_t    stat,
	output mws_pkg::cmd_t     cmd
);
	import mws_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAT_UPD,
		S_TXT_UPD,
		S_SHR_CHK,
		S_SHR_TXT,
		S_SHR_CNT
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) &&
	                  ((in_data.opcode != OP_FINISH) || !stat.out_busy);
	assign accept   = in_valid & in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_data.opcode)
						OP_PATTERN: begin
							if (!stat.right_zero) begin
								cmd = '0;
							end else if (stat.pat_full) begin
								cmd.ovf_set = 1'b1;
							end else begin
								cmd.pat_rd = 1'b1;
								state_d    = S_PAT_UPD;
							end
						end
						OP_TEXT: begin
							if (stat.text_full) begin
								cmd.ovf_set = 1'b1;
							end else begin
								cmd.txt_wr = 1'b1;
								if (!stat.plen_zero) begin
									state_d = S_TXT_UPD;
								end
							end
						end
						OP_FINISH: begin
							cmd.fin = 1'b1;
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			S_PAT_UPD: begin
				cmd.pat_upd = 1'b1;
				state_d     = S_IDLE;
			end
			S_TXT_UPD: begin
				cmd.txt_upd = 1'b1;
				state_d     = S_SHR_CHK;
			end
			S_SHR_CHK: begin
				if (stat.shrink_go) begin
					cmd.shr_best = 1'b1;
					state_d      = S_SHR_TXT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SHR_TXT: begin
				cmd.shr_rd = 1'b1;
				state_d    = S_SHR_CNT;
			end
			S_SHR_CNT: begin
				cmd.shr_upd = 1'b1;
				state_d     = S_SHR_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/minimum_window_substring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimum_window_substring
// Shortest text window holding every pattern character with multiplicity.
// ----------------------------------------------------------------------------
// Load pattern beats first, then text beats, then one finish beat, which
// gives a single result beat and clears the block. A pattern beat does a
// read-modify-write of the per-code count memory, whose read is registered;
// a text beat is stored and, unless the pattern is empty, does the same and
// then runs the shrink loop. Each character that leaves the window at its
// left edge costs a best window update with a text memory read, then a
// count read-modify-write; every character leaves at most once. A new beat
// is taken only once the last one is done. The result register frees the
// input side while a result waits to be taken; only a finish beat waits for
// it.
module minimum_window_substring #(
	parameter int MAX_TEXT      = mws_pkg::DEF_MAX_TEXT,
	parameter int MAX_PATTERN   = mws_pkg::DEF_MAX_PATTERN,
	parameter int ALPHABET_SIZE = mws_pkg::DEF_ALPHABET_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mws_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mws_pkg::out_beat_t out_data
);
	import mws_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.stat     (stat),
		.cmd      (cmd)
	);

	mws_dp #(
		.MAX_TEXT      (MAX_TEXT),
		.MAX_PATTERN   (MAX_PATTERN),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
